// ----- rtl/smva_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smva_pkg
// Shared types, codes and arithmetic helpers of the scaled matrix-vector
// accumulate block (signed Q16.16 data, saturating).
// ----------------------------------------------------------------------------
package smva_pkg;

  localparam int DATA_W = 32;
  localparam int PROD_W = 64;
  localparam int TERM_W = 48;
  localparam int CC_W   = 6;

  localparam logic [CC_W-1:0]   CC_RESET   = 6'd16;
  localparam logic [PROD_W-1:0] ROUND_BIAS = 64'd32768;

  typedef enum logic [2:0] {
    FN_MATRIX   = 3'd0,
    FN_SOURCE   = 3'd1,
    FN_INTERACT = 3'd2,
    FN_LSCALE   = 3'd3,
    FN_EMIT     = 3'd4
  } func_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SRC_MUL,
    ST_SRC_WR,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT_MUL,
    ST_EMIT_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_SRC,
    OP_MAT,
    OP_EMIT
  } op_sel_e;

  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_ACC,
    BASE_OLD
  } base_sel_e;

  typedef struct packed {
    logic [2:0]               func;
    logic [4:0]               row_index;
    logic [4:0]               col_index;
    logic [6:0]               dest_slot;
    logic signed [DATA_W-1:0] matrix_value;
    logic signed [DATA_W-1:0] multipole_value;
    logic signed [DATA_W-1:0] source_scale_value;
    logic signed [DATA_W-1:0] local_scale_value;
    logic signed [DATA_W-1:0] old_local_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_local_value;
    logic [6:0]               out_slot;
    logic [4:0]               out_coeff;
  } out_item_t;

  typedef struct packed {
    logic      mul_en;
    op_sel_e   op_sel;
    base_sel_e base_sel;
    logic      acc_en;
    logic      acc_clr;
    logic      acc_old_load;
    logic      src_we;
    logic      acc_we;
    logic      acc_wzero;
    logic      out_load;
  } ctl_t;

  // q32.32 product to q16.16, round half up
  function automatic logic signed [TERM_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = PROD_W'(p) + ROUND_BIAS;
    return TERM_W'(s[PROD_W-1:PROD_W-TERM_W]);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(64'sh0000_0000_7FFF_FFFF);
    lo = PROD_W'(-64'sh0000_0000_8000_0000);
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return DATA_W'(v);
  endfunction

endpackage

// ----- rtl/smva_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smva_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smva_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/smva_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smva_mac
// Shared multiply, round, accumulate and saturate unit.
// ----------------------------------------------------------------------------
module smva_mac #(
  parameter int SUM_W = 53
) (
  input  logic                clk,
  input  smva_pkg::ctl_t      ctl,
  input  logic signed [31:0]  op_a,
  input  logic signed [31:0]  op_b,
  input  logic signed [31:0]  base,
  output logic signed [31:0]  result
);
  import smva_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [TERM_W-1:0] term;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [SUM_W:0]    total;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= op_a * op_b;
    end
    sum_r <= sum_nxt;
  end

  assign term = round_q(prod_r);

  always_comb begin
    if (ctl.acc_clr) begin
      sum_nxt = '0;
    end else if (ctl.acc_en) begin
      sum_nxt = SUM_W'(sum_r + SUM_W'(term));
    end else begin
      sum_nxt = sum_r;
    end
  end

  assign total  = (SUM_W+1)'(base) + (SUM_W+1)'(sum_r) + (SUM_W+1)'(term);
  assign result = sat32(PROD_W'(total));

endmodule

// ----- rtl/smva_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smva_seq
// Sequencer: clearing pass, command decode, interaction loop counters and
// the control pipeline that drives the shared mac unit and the memories.
// ----------------------------------------------------------------------------
module smva_seq #(
  parameter int MAX_COEFFS  = 32,
  parameter int MAX_TARGETS = 128,
  parameter int CIW         = 5,
  parameter int TW          = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  smva_pkg::in_item_t     in_data,
  input  logic [5:0]             coeff_count,
  output logic                   busy,
  output smva_pkg::ctl_t         ctl,
  output logic [2*CIW-1:0]       mat_raddr,
  output logic [CIW-1:0]         src_raddr,
  output logic [CIW-1:0]         src_waddr,
  output logic [CIW-1:0]         ls_raddr,
  output logic [TW+CIW-1:0]      acc_raddr,
  output logic [TW+CIW-1:0]      acc_waddr
);
  import smva_pkg::*;

  state_e              state_r, state_nxt;
  logic [CIW-1:0]      a_r, a_nxt;
  logic [CIW-1:0]      b_r, b_nxt;
  logic [TW+CIW-1:0]   clr_r, clr_nxt;
  logic [TW-1:0]       slot_r;
  logic [CIW-1:0]      alpha_r;
  logic [CIW-1:0]      beta_r;
  logic [CIW-1:0]      n_m1;
  logic                v1_r, last1_r, fin1_r;
  logic                v2_r, last2_r, fin2_r;
  logic [CIW-1:0]      b1_r, b2_r;
  logic                issue_v, issue_last, issue_fin;
  logic                accept;
  logic                alpha_ok, beta_ok, slot_ok;

  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);
  assign alpha_ok = int'(in_data.row_index) < MAX_COEFFS;
  assign beta_ok  = int'(in_data.col_index) < MAX_COEFFS;
  assign slot_ok  = int'(in_data.dest_slot) < MAX_TARGETS;

  always_comb begin
    if (coeff_count == '0) begin
      n_m1 = '0;
    end else if (int'(coeff_count) > MAX_COEFFS) begin
      n_m1 = CIW'(MAX_COEFFS - 1);
    end else begin
      n_m1 = CIW'(coeff_count - 6'd1);
    end
  end

  assign issue_v    = (state_r == ST_RUN);
  assign issue_last = (a_r == n_m1);
  assign issue_fin  = issue_last && (b_r == n_m1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          unique case (in_data.func)
            FN_SOURCE:   if (alpha_ok) state_nxt = ST_SRC_MUL;
            FN_INTERACT: if (slot_ok) state_nxt = ST_RUN;
            FN_EMIT:     if (slot_ok && beta_ok) state_nxt = ST_EMIT_MUL;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SRC_MUL:  state_nxt = ST_SRC_WR;
      ST_SRC_WR:   state_nxt = ST_IDLE;
      ST_RUN: begin
        if (issue_fin) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (v2_r && fin2_r) state_nxt = ST_IDLE;
      end
      ST_EMIT_MUL: state_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT: state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    clr_nxt = clr_r;
    if (state_r == ST_CLEAR) begin
      clr_nxt = clr_r + 1'b1;
    end
    if (accept) begin
      a_nxt = '0;
      b_nxt = '0;
    end else if (issue_v) begin
      if (issue_last) begin
        a_nxt = '0;
        b_nxt = b_r + 1'b1;
      end else begin
        a_nxt = a_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      v1_r    <= issue_v;
      v2_r    <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    last1_r <= issue_last;
    fin1_r  <= issue_fin;
    b1_r    <= b_r;
    last2_r <= last1_r;
    fin2_r  <= fin1_r;
    b2_r    <= b1_r;
    if (accept) begin
      slot_r  <= TW'(in_data.dest_slot);
      alpha_r <= CIW'(in_data.row_index);
      beta_r  <= CIW'(in_data.col_index);
    end
  end

  // outputs
  always_comb begin
    ctl          = '0;
    ctl.op_sel   = OP_MAT;
    ctl.base_sel = BASE_ZERO;
    mat_raddr    = {a_r, b_r};
    src_raddr    = a_r;
    src_waddr    = alpha_r;
    ls_raddr     = CIW'(in_data.col_index);
    acc_raddr    = {TW'(in_data.dest_slot), CIW'(in_data.col_index)};
    acc_waddr    = {slot_r, b2_r};
    unique case (state_r)
      ST_CLEAR: begin
        ctl.acc_we    = 1'b1;
        ctl.acc_wzero = 1'b1;
        ctl.acc_clr   = 1'b1;
        acc_waddr     = clr_r;
      end
      ST_IDLE: begin
        ctl.acc_clr = 1'b1;
      end
      ST_SRC_MUL: begin
        ctl.mul_en = 1'b1;
        ctl.op_sel = OP_SRC;
      end
      ST_SRC_WR: begin
        ctl.src_we = 1'b1;
      end
      ST_RUN, ST_DRAIN: begin
        acc_raddr        = {slot_r, b_r};
        ctl.mul_en       = v1_r;
        ctl.acc_old_load = v1_r && last1_r;
        ctl.base_sel     = BASE_ACC;
        ctl.acc_en       = v2_r && !last2_r;
        ctl.acc_clr      = v2_r && last2_r;
        ctl.acc_we       = v2_r && last2_r;
      end
      ST_EMIT_MUL: begin
        ctl.mul_en    = 1'b1;
        ctl.op_sel    = OP_EMIT;
        ctl.acc_we    = 1'b1;
        ctl.acc_wzero = 1'b1;
        acc_waddr     = {slot_r, beta_r};
      end
      ST_EMIT_OUT: begin
        ctl.base_sel = BASE_OLD;
        ctl.out_load = 1'b1;
      end
      default: begin
        ctl.acc_clr = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/scaled_matrix_vector_accumulate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_matrix_vector_accumulate
// Matrix and scale loads, matrix^T times scaled source accumulation per
// target slot, and emit of scaled accumulator onto the old local value.
// ----------------------------------------------------------------------------
// matrix and local scale loads: written at the accept edge, busy stays low
// source load: busy in ST_SRC_MUL and ST_SRC_WR (one pass through the shared multiplier)
// interaction: busy in ST_RUN (n*n macs, one per cycle) and ST_DRAIN; n = coeff_count
// emit: busy in ST_EMIT_MUL and ST_EMIT_OUT, result strobe registered from ST_EMIT_OUT
// reset: all 2^(ceil(log2 MAX_TARGETS) + ceil(log2 MAX_COEFFS)) accumulator ram entries
// (4096 by default) cleared one entry per cycle with busy high; no back-pressure
module scaled_matrix_vector_accumulate #(
  parameter int MAX_COEFFS  = 32,
  parameter int MAX_TARGETS = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  smva_pkg::in_item_t  in_data,
  output logic                out_valid,
  output smva_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_wdata
);
  import smva_pkg::*;

  localparam int CIW   = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
  localparam int TW    = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int SUM_W = TERM_W + CIW;

  logic [CC_W-1:0]     cc_r;
  in_item_t            item_r;
  logic signed [31:0]  acc_old_r;
  logic                out_valid_r;
  out_item_t           out_data_r;
  ctl_t                ctl;
  logic                accept;

  logic [2*CIW-1:0]    mat_raddr;
  logic [CIW-1:0]      src_raddr, src_waddr, ls_raddr;
  logic [TW+CIW-1:0]   acc_raddr, acc_waddr;
  logic [DATA_W-1:0]   mat_rdata, src_rdata, ls_rdata, acc_rdata, acc_wdata;
  logic                mat_we, ls_we;
  logic signed [31:0]  op_a, op_b, base, result;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r        <= CC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cc_r <= cfg_wdata;
      out_valid_r <= ctl.out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    if (ctl.acc_old_load) acc_old_r <= acc_rdata;
    if (ctl.out_load) begin
      out_data_r.new_local_value <= result;
      out_data_r.out_slot        <= item_r.dest_slot;
      out_data_r.out_coeff       <= item_r.col_index;
    end
  end

  assign mat_we = accept && (in_data.func == FN_MATRIX) &&
                  (int'(in_data.row_index) < MAX_COEFFS) &&
                  (int'(in_data.col_index) < MAX_COEFFS);
  assign ls_we  = accept && (in_data.func == FN_LSCALE) &&
                  (int'(in_data.col_index) < MAX_COEFFS);

  smva_seq #(
    .MAX_COEFFS  (MAX_COEFFS),
    .MAX_TARGETS (MAX_TARGETS),
    .CIW         (CIW),
    .TW          (TW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_data     (in_data),
    .coeff_count (cc_r),
    .busy        (busy),
    .ctl         (ctl),
    .mat_raddr   (mat_raddr),
    .src_raddr   (src_raddr),
    .src_waddr   (src_waddr),
    .ls_raddr    (ls_raddr),
    .acc_raddr   (acc_raddr),
    .acc_waddr   (acc_waddr)
  );

  smva_ram #(.WIDTH(DATA_W), .DEPTH(1 << (2 * CIW))) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr ({CIW'(in_data.row_index), CIW'(in_data.col_index)}),
    .wdata (in_data.matrix_value),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  smva_ram #(.WIDTH(DATA_W), .DEPTH(1 << CIW)) u_src_ram (
    .clk   (clk),
    .we    (ctl.src_we),
    .waddr (src_waddr),
    .wdata (result),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  smva_ram #(.WIDTH(DATA_W), .DEPTH(1 << CIW)) u_ls_ram (
    .clk   (clk),
    .we    (ls_we),
    .waddr (CIW'(in_data.col_index)),
    .wdata (in_data.local_scale_value),
    .raddr (ls_raddr),
    .rdata (ls_rdata)
  );

  assign acc_wdata = ctl.acc_wzero ? '0 : result;

  smva_ram #(.WIDTH(DATA_W), .DEPTH(1 << (TW + CIW))) u_acc_ram (
    .clk   (clk),
    .we    (ctl.acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  always_comb begin
    case (ctl.op_sel)
      OP_SRC: begin
        op_a = item_r.source_scale_value;
        op_b = item_r.multipole_value;
      end
      OP_EMIT: begin
        op_a = ls_rdata;
        op_b = acc_rdata;
      end
      default: begin
        op_a = mat_rdata;
        op_b = src_rdata;
      end
    endcase
    case (ctl.base_sel)
      BASE_ACC: base = acc_old_r;
      BASE_OLD: base = item_r.old_local_value;
      default:  base = '0;
    endcase
  end

  smva_mac #(.SUM_W(SUM_W)) u_mac (
    .clk    (clk),
    .ctl    (ctl),
    .op_a   (op_a),
    .op_b   (op_b),
    .base   (base),
    .result (result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/smva_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smva_props
// Port-level checks of the scaled matrix-vector accumulate block.
// ----------------------------------------------------------------------------
module smva_props #(
  parameter int MAX_TARGETS = 128
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input smva_pkg::in_item_t  in_data,
  input logic                out_valid
);
  import smva_pkg::*;

  // an emit gives one result beat, never two in a row
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result beats");

  // a result beat always follows a busy cycle of its emit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without preceding work");

  // an in-range interaction keeps the block busy
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.func == FN_INTERACT) &&
     (int'(in_data.dest_slot) < MAX_TARGETS)) |=> busy)
    else $error("interaction accepted without busy");

  // no result while an interaction is just starting
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.func == FN_INTERACT)) |=> !out_valid)
    else $error("result beat after interaction accept");

endmodule

bind scaled_matrix_vector_accumulate smva_props #(
  .MAX_TARGETS (MAX_TARGETS)
) u_smva_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid)
);

// ----- tb/smva_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smva_checker
// Watches the command, result and coefficient-count ports of the scaled
// matrix-vector accumulate block and keeps its own copy of the matrix, scaled
// source, local scale and accumulator stores. Every accepted emit beat yields
// one expected local value; each result strobe is compared field by field
// with the oldest one still waiting.
// ----------------------------------------------------------------------------
module smva_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  smva_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  smva_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_wdata,
  output int                  fail_count,
  output int                  pending,
  output int                  results_seen
);
  import smva_pkg::*;

  logic signed [31:0] mat_q    [32][32];
  logic signed [31:0] src_q    [32];
  logic signed [31:0] lscale_q [32];
  logic signed [31:0] acc_q    [128][32];
  logic [5:0]         coeff_count;
  out_item_t          expected_locals [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
  end

  // q32.32 to q16.16, half rounds up
  function automatic longint round_to_q16(input longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp_q16(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return 32'(v);
  endfunction

  task automatic apply_beat(input in_item_t it);
    int        n;
    int        a;
    int        b;
    longint    total;
    out_item_t want;
    n = (coeff_count == 0) ? 1 : (coeff_count > 32) ? 32 : int'(coeff_count);
    case (it.func)
      FN_MATRIX: begin
        mat_q[it.row_index][it.col_index] = it.matrix_value;
      end
      FN_SOURCE: begin
        src_q[it.row_index] = clamp_q16(round_to_q16(
            longint'($signed(it.source_scale_value)) *
            longint'($signed(it.multipole_value))));
      end
      FN_INTERACT: begin
        for (b = 0; b < n; b++) begin
          total = 0;
          for (a = 0; a < n; a++) begin
            total += round_to_q16(longint'(mat_q[a][b]) * longint'(src_q[a]));
          end
          acc_q[it.dest_slot][b] = clamp_q16(longint'(acc_q[it.dest_slot][b]) + total);
        end
      end
      FN_LSCALE: begin
        lscale_q[it.col_index] = it.local_scale_value;
      end
      FN_EMIT: begin
        want.new_local_value = clamp_q16(longint'($signed(it.old_local_value)) +
            round_to_q16(longint'(lscale_q[it.col_index]) *
                         longint'(acc_q[it.dest_slot][it.col_index])));
        want.out_slot  = it.dest_slot;
        want.out_coeff = it.col_index;
        acc_q[it.dest_slot][it.col_index] = '0;
        expected_locals.insert(expected_locals.size(), want);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (expected_locals.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: result with nothing expected: local %h slot %0d coeff %0d",
                 $time, got.new_local_value, got.out_slot, got.out_coeff);
      end
      return;
    end
    want = expected_locals.pop_front();
    if (got.new_local_value !== want.new_local_value || got.out_slot !== want.out_slot ||
        got.out_coeff !== want.out_coeff) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: expected local %h slot %0d coeff %0d, got local %h slot %0d coeff %0d",
                 $time, want.new_local_value, want.out_slot, want.out_coeff,
                 got.new_local_value, got.out_slot, got.out_coeff);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (acc_q[s, c]) begin
        acc_q[s][c] = '0;
      end
      coeff_count = CC_RESET;
      expected_locals.delete();
    end else begin
      if (start && !busy) begin
        apply_beat(in_data);
      end
      if (out_valid) begin
        check_result(out_data);
      end
      if (cfg_we) begin
        coeff_count = cfg_wdata;
      end
    end
    pending = expected_locals.size();
  end

endmodule

// ----- tb/tb_scaled_matrix_vector_accumulate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scaled_matrix_vector_accumulate
// Drives command beats into the scaled matrix-vector accumulate block: a
// directed run over saturation, rounding ties, edge slots and coefficients
// and the spare function codes, then random load / interaction / emit
// sequences under several coefficient counts up to sixteen. Stores are
// always filled before they are read. The checker predicts and compares;
// this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_scaled_matrix_vector_accumulate;
  import smva_pkg::*;

  localparam logic [2:0] FN_SPARE_A = 3'd5;
  localparam logic [2:0] FN_SPARE_B = 3'd6;
  localparam logic [2:0] FN_SPARE_C = 3'd7;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_data;
  logic       out_valid;
  out_item_t  out_data;
  logic       cfg_we;
  logic [5:0] cfg_wdata;
  int         fail_count;
  int         pending;
  int         results_seen;

  int n_eff;
  bit mat_wr [32][32];
  bit src_wr [32];
  bit ls_wr  [32];
  int beats_by_func [8];
  int real_beats;
  int cc_writes;
  bit no_idle;

  scaled_matrix_vector_accumulate u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  smva_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic signed [31:0] rand_q16();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0:          return 32'sh7FFF_FFFF;
      1:          return 32'sh8000_0000;
      2:          return '0;
      3:          return 32'sh0001_0000;
      4:          return 32'shFFFF_0000;
      5, 6, 7, 8: return $urandom;
      default:    return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
    endcase
  endfunction

  function automatic in_item_t mk_beat(input logic [2:0] f, input int r, input int c,
                                       input int s);
    in_item_t it;
    it.func               = f;
    it.row_index          = 5'(r);
    it.col_index          = 5'(c);
    it.dest_slot          = 7'(s);
    it.matrix_value       = rand_q16();
    it.multipole_value    = rand_q16();
    it.source_scale_value = rand_q16();
    it.local_scale_value  = rand_q16();
    it.old_local_value    = rand_q16();
    return it;
  endfunction

  // most traffic on a few slots so emits see built-up accumulators
  function automatic int pick_slot();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(0, 7);
    end else if (r < 85) begin
      return ($urandom_range(0, 1) == 0) ? 0 : 127;
    end
    return $urandom_range(0, 127);
  endfunction

  task automatic pause();
    int r;
    int len;
    if (no_idle) begin
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      len = 0;
    end else if (r < 85) begin
      len = $urandom_range(1, 3);
    end else if (r < 97) begin
      len = $urandom_range(4, 12);
    end else begin
      len = $urandom_range(20, 60);
    end
    if (len > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (len - 1) @(negedge clk);
    end
  endtask

  task automatic send_beat(input in_item_t it);
    @(negedge clk);
    start   = 1'b1;
    in_data = it;
    while (busy) @(negedge clk);
    @(posedge clk);
    beats_by_func[it.func]++;
    if (it.func <= FN_EMIT) begin
      real_beats++;
    end
    case (it.func)
      FN_MATRIX: mat_wr[it.row_index][it.col_index] = 1'b1;
      FN_SOURCE: src_wr[it.row_index] = 1'b1;
      FN_LSCALE: ls_wr[it.col_index] = 1'b1;
      default: begin
      end
    endcase
    pause();
  endtask

  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (busy || pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_coeff_count(input logic [5:0] v);
    settle();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    n_eff  = (v == 0) ? 1 : (v > 32) ? 32 : int'(v);
    cc_writes++;
  endtask

  // an interaction reads every matrix and source entry below n
  task automatic load_missing_terms();
    int a;
    int b;
    for (a = 0; a < n_eff; a++) begin
      if (!src_wr[a]) begin
        send_beat(mk_beat(FN_SOURCE, a, $urandom_range(0, 31), $urandom_range(0, 127)));
      end
      for (b = 0; b < n_eff; b++) begin
        if (!mat_wr[a][b]) begin
          send_beat(mk_beat(FN_MATRIX, a, b, $urandom_range(0, 127)));
        end
      end
    end
  endtask

  task automatic emit_one(input int s, input int b);
    if (!ls_wr[b]) begin
      send_beat(mk_beat(FN_LSCALE, $urandom_range(0, 31), b, $urandom_range(0, 127)));
    end
    send_beat(mk_beat(FN_EMIT, $urandom_range(0, 31), b, s));
  endtask

  task automatic interaction_sequence(input int s, input int max_emits);
    int reps;
    int b;
    reps = $urandom_range(0, 2);
    repeat (reps) begin
      send_beat(mk_beat(FN_SOURCE, $urandom_range(0, n_eff - 1), $urandom_range(0, 31),
                        $urandom_range(0, 127)));
    end
    load_missing_terms();
    reps = $urandom_range(1, 3);
    repeat (reps) begin
      send_beat(mk_beat(FN_INTERACT, $urandom_range(0, 31), $urandom_range(0, 31), s));
    end
    reps = $urandom_range(1, (n_eff < max_emits) ? n_eff : max_emits);
    repeat (reps) begin
      b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, n_eff - 1);
      emit_one(s, b);
    end
  endtask

  task automatic random_phase(input int quota);
    int       first;
    int       kind;
    logic [2:0] spare;
    first   = real_beats;
    no_idle = ($urandom_range(0, 3) == 0);
    while (real_beats - first < quota) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        interaction_sequence(pick_slot(), 6);
      end else if (kind < 60) begin
        send_beat(mk_beat(FN_MATRIX, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 127)));
      end else if (kind < 70) begin
        send_beat(mk_beat(FN_SOURCE, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 127)));
      end else if (kind < 78) begin
        send_beat(mk_beat(FN_LSCALE, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 127)));
      end else if (kind < 90) begin
        emit_one(pick_slot(), $urandom_range(0, 31));
      end else if (kind < 95) begin
        load_missing_terms();
        send_beat(mk_beat(FN_INTERACT, $urandom_range(0, 31), $urandom_range(0, 31),
                          pick_slot()));
      end else begin
        case ($urandom_range(0, 2))
          0:       spare = FN_SPARE_A;
          1:       spare = FN_SPARE_B;
          default: spare = FN_SPARE_C;
        endcase
        send_beat(mk_beat(spare, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 127)));
      end
    end
  endtask

  initial begin
    in_item_t b;
    int       k;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    n_eff      = 16;
    real_beats = 0;
    cc_writes  = 0;
    no_idle    = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    settle();

    // directed: saturation, rounding ties, edge slots and coefficients
    set_coeff_count(6'd1);
    b = mk_beat(FN_MATRIX, 0, 0, 0);
    b.matrix_value = 32'sh7FFF_FFFF;
    send_beat(b);
    b = mk_beat(FN_SOURCE, 0, 0, 0);
    b.source_scale_value = 32'sh8000_0000;
    b.multipole_value    = 32'sh8000_0000;
    send_beat(b);
    send_beat(mk_beat(FN_INTERACT, 0, 0, 0));
    send_beat(mk_beat(FN_INTERACT, 31, 31, 0));
    b = mk_beat(FN_LSCALE, 0, 0, 0);
    b.local_scale_value = 32'sh0001_0000;
    send_beat(b);
    b = mk_beat(FN_EMIT, 0, 0, 0);
    b.old_local_value = 32'sh7FFF_FFFF;
    send_beat(b);
    b = mk_beat(FN_EMIT, 0, 0, 0);
    b.old_local_value = 32'sh0000_0005;
    send_beat(b);
    b = mk_beat(FN_MATRIX, 0, 0, 0);
    b.matrix_value = 32'sh8000_0000;
    send_beat(b);
    send_beat(mk_beat(FN_INTERACT, 0, 0, 127));
    b = mk_beat(FN_LSCALE, 0, 0, 0);
    b.local_scale_value = 32'sh7FFF_FFFF;
    send_beat(b);
    b = mk_beat(FN_EMIT, 0, 0, 127);
    b.old_local_value = 32'sh8000_0000;
    send_beat(b);
    // positive tie rounds up
    b = mk_beat(FN_MATRIX, 0, 0, 0);
    b.matrix_value = 32'sh0000_8000;
    send_beat(b);
    b = mk_beat(FN_SOURCE, 0, 0, 0);
    b.source_scale_value = 32'sh0000_0001;
    b.multipole_value    = 32'sh0001_0000;
    send_beat(b);
    send_beat(mk_beat(FN_INTERACT, 0, 0, 5));
    // negative tie rounds toward zero
    b = mk_beat(FN_SOURCE, 0, 0, 0);
    b.source_scale_value = 32'shFFFF_FFFF;
    b.multipole_value    = 32'sh0001_0000;
    send_beat(b);
    send_beat(mk_beat(FN_INTERACT, 0, 0, 5));
    b = mk_beat(FN_LSCALE, 0, 0, 0);
    b.local_scale_value = 32'sh0001_0000;
    send_beat(b);
    b = mk_beat(FN_EMIT, 0, 0, 5);
    b.old_local_value = '0;
    send_beat(b);
    // coefficient beyond n still loads and emits
    b = mk_beat(FN_LSCALE, 31, 31, 0);
    b.local_scale_value = 32'sh8000_0000;
    send_beat(b);
    send_beat(mk_beat(FN_EMIT, 31, 31, 3));
    b = mk_beat(FN_MATRIX, 31, 31, 0);
    b.matrix_value = 32'sh1234_5678;
    send_beat(b);
    send_beat(mk_beat(FN_SPARE_A, 31, 31, 127));
    send_beat(mk_beat(FN_SPARE_B, 0, 0, 0));
    send_beat(mk_beat(FN_SPARE_C, 17, 9, 64));

    // random sequences under several coefficient counts
    set_coeff_count(6'd0);
    random_phase(65);
    set_coeff_count(6'd3);
    random_phase(65);
    set_coeff_count(6'd8);
    random_phase(65);
    set_coeff_count(6'd16);
    random_phase(65);
    set_coeff_count(6'd2);
    random_phase(65);
    set_coeff_count(6'd11);
    random_phase(65);

    @(negedge clk);
    start = 1'b0;
    for (k = 0; k < 20000 && pending != 0; k++) @(negedge clk);
    repeat (16) @(negedge clk);
    if (pending != 0) begin
      $display("%0d expected results never arrived", pending);
    end
    $display("covered %0d beats: %0d matrix, %0d source, %0d interaction, %0d scale, %0d emit",
             real_beats, beats_by_func[FN_MATRIX], beats_by_func[FN_SOURCE],
             beats_by_func[FN_INTERACT], beats_by_func[FN_LSCALE], beats_by_func[FN_EMIT]);
    $display("%0d spare-code beats, %0d coefficient count writes, %0d results checked",
             beats_by_func[FN_SPARE_A] + beats_by_func[FN_SPARE_B] + beats_by_func[FN_SPARE_C],
             cc_writes, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("run timed out");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
